// ===== hdl/dfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared types, constants and colormap tables of the dB to false-colour
// pixel core.
// ----------------------------------------------------------------------------
package dfc_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned SAMPLE_BITS_DEF   = 16;

  localparam int unsigned FLOOR_W   = 16;
  localparam int unsigned SPAN_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CHAN_W    = 8;

  localparam int unsigned NUM_STOPS = 7;
  localparam int unsigned NUM_SEG   = NUM_STOPS - 1;
  localparam int unsigned SEG_W     = 3;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned RECIP_W   = 14;

  localparam logic signed [FLOOR_W-1:0] DB_FLOOR_RESET = -16'sd25600;
  localparam logic [SPAN_W-1:0]         INV_SPAN_RESET = 32'd167772;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DB_FLOOR = 1'b0,
    CFG_INV_SPAN = 1'b1
  } cfg_idx_e;

  // Stage advance strobes for the per-channel interpolation stages.
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } dfc_adv_t;

  localparam logic [7:0] STOP_PCT [NUM_STOPS] = '{
    8'd0, 8'd15, 8'd35, 8'd55, 8'd75, 8'd90, 8'd100
  };

  localparam logic [CHAN_W-1:0] STOP_RGB [NUM_STOPS][NUM_CHAN] = '{
    '{8'd8,   8'd0,   8'd64 },
    '{8'd0,   8'd0,   8'd180},
    '{8'd0,   8'd160, 8'd200},
    '{8'd0,   8'd210, 8'd80 },
    '{8'd230, 8'd230, 8'd0  },
    '{8'd255, 8'd120, 8'd0  },
    '{8'd255, 8'd255, 8'd255}
  };

  // Stop position in fixed point, rounded to nearest.
  function automatic logic [31:0] stop_pos(input logic [7:0] pct, input int unsigned fb);
    logic [63:0] num;
    num = (64'(pct) << fb) + 64'd50;
    return 32'(num / 64'd100);
  endfunction

endpackage

// ===== hdl/dfc_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfc_sample_if
// Valid/ready channel carrying one dB sample per transaction.
// ----------------------------------------------------------------------------
interface dfc_sample_if
  import dfc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_db;

  modport source (output valid, output sample_db, input ready);
  modport sink   (input valid, input sample_db, output ready);
endinterface

// ===== hdl/dfc_pixel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfc_pixel_if
// Valid/ready channel carrying one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface dfc_pixel_if
  import dfc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hdl/db_to_false_color_pixel_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// db_to_false_color_pixel_core
// Maps a Q8.8 dB spectrum sample to an RGB pixel through a seven-stop
// piecewise-linear colormap.
// ----------------------------------------------------------------------------
// The core takes one sample transaction per clock unless the pixel sink
// stalls it, and returns one pixel transaction per sample, in order, from a
// seven-stage pipeline: offset from the floor, the 32x32 scaling product,
// position clamp and segment search, then four stages per colour channel
// that scale the in-segment offset and divide by the segment width through
// a constant reciprocal and one correction step. Each stage has its own
// valid bit and advances whenever the stage after it is empty or moving,
// so bubbles close up and a stalled pixel sink holds the pipeline without
// loss; the sample side stays ready while any stage is empty.
// Configuration (db_floor at index 0, inverse_span at index 1) is written
// through cfg_we_i and takes effect for samples accepted afterwards; write
// it only while the pipeline is empty.
// ----------------------------------------------------------------------------
module db_to_false_color_pixel_core
  import dfc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  dfc_sample_if.sink           sample_i,
  dfc_pixel_if.source          pixel_o
);

  localparam int unsigned TW    = FRACTION_BITS + 1;
  localparam int unsigned DW    = ((SAMPLE_BITS > FLOOR_W) ? SAMPLE_BITS : FLOOR_W) + 1;
  localparam int unsigned NSTG  = 7;
  localparam logic [TW-1:0] T_ONE = TW'(1) << FRACTION_BITS;

  localparam logic [TW-1:0] POS [NUM_STOPS] = '{
    TW'(stop_pos(STOP_PCT[0], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[1], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[2], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[3], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[4], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[5], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[6], FRACTION_BITS))
  };

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [FLOOR_W-1:0] db_floor_q;
  logic [SPAN_W-1:0]         inv_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_floor_q <= DB_FLOOR_RESET;
      inv_span_q <= INV_SPAN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DB_FLOOR: db_floor_q <= signed'(cfg_data_i[FLOOR_W-1:0]);
        CFG_INV_SPAN: inv_span_q <= cfg_data_i[SPAN_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: one valid bit per stage, index 0 is stage 1
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] adv;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    adv[NSTG-1] = !vld_q[NSTG-1] || pixel_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= sample_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign sample_i.ready = adv[0];
  assign pixel_o.valid  = vld_q[NSTG-1];

  // --------------------------------------------------------------------------
  // Stage 1: exact offset from the floor
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] d_d, d_q;

  assign d_d = DW'(sample_i.sample_db) - DW'(db_floor_q);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      d_q <= d_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale by the reciprocal span. A positive offset always fits in
  // 32 bits, so the upper half never forces saturation here.
  // --------------------------------------------------------------------------
  logic [2*SPAN_W-1:0] prod_d, prod_q;
  logic                zero_d, zero_q;

  assign zero_d = d_q[DW-1] || (d_q == '0) || (inv_span_q == '0);
  assign prod_d = (2*SPAN_W)'(d_q[DW-2:0]) * (2*SPAN_W)'(inv_span_q);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      prod_q <= prod_d;
      zero_q <= zero_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: clamp the position and find its segment; a tie at a stop takes
  // the lower segment
  // --------------------------------------------------------------------------
  logic [2*SPAN_W-1:0] shifted;
  logic [TW-1:0]       t_s3;
  logic [SEG_W-1:0]    seg_d, seg_q;
  logic [TW-1:0]       off_d, off_q;
  logic                found;

  always_comb begin
    shifted = prod_q >> (SPAN_W - FRACTION_BITS);
    if (zero_q) begin
      t_s3 = '0;
    end else if (shifted > (2*SPAN_W)'(T_ONE)) begin
      t_s3 = T_ONE;
    end else begin
      t_s3 = shifted[TW-1:0];
    end
    seg_d = SEG_W'(NUM_SEG - 1);
    found = 1'b0;
    for (int i = 1; i < NUM_STOPS; i++) begin
      if (!found && (POS[i] >= t_s3)) begin
        seg_d = SEG_W'(i - 1);
        found = 1'b1;
      end
    end
    off_d = t_s3 - POS[seg_d];
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      seg_q <= seg_d;
      off_q <= off_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 to 7: per-channel interpolation
  // --------------------------------------------------------------------------
  dfc_adv_t          chan_adv;
  logic [CHAN_W-1:0] chan_val [NUM_CHAN];

  assign chan_adv = '{s4: adv[3], s5: adv[4], s6: adv[5], s7: adv[6]};

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    dfc_chan #(
      .FRACTION_BITS (FRACTION_BITS),
      .CH            (c)
    ) u_chan (
      .clk_i   (clk_i),
      .adv_i   (chan_adv),
      .seg_i   (seg_q),
      .off_i   (off_q),
      .value_o (chan_val[c])
    );
  end

  assign pixel_o.red   = chan_val[0];
  assign pixel_o.green = chan_val[1];
  assign pixel_o.blue  = chan_val[2];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic acc_in, acc_out;
  assign acc_in  = sample_i.valid && sample_i.ready;
  assign acc_out = pixel_o.valid && pixel_o.ready;

  // With the sink stalled, the sample side is ready exactly when a bubble exists.
  a_ready_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pixel_o.ready |-> (sample_i.ready == !(&vld_q)))
    else $error("sample ready disagrees with pipeline occupancy");

  // Occupancy changes only by accepted and delivered transactions.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(vld_q) ==
      $countones($past(vld_q)) + $past(acc_in) - $past(acc_out)))
    else $error("transaction lost or duplicated in pipeline");

  // The in-segment offset never exceeds the segment width.
  a_off_in_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> ((seg_q < SEG_W'(NUM_SEG)) &&
      (off_q <= POS[seg_q + SEG_W'(1)] - POS[seg_q])))
    else $error("segment offset out of range");

endmodule

// ===== hdl/dfc_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfc_chan
// Four-stage linear interpolation of one colour channel within a segment,
// dividing by the segment width through a reciprocal and one correction.
// ----------------------------------------------------------------------------
module dfc_chan
  import dfc_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int unsigned CH            = 0
) (
  input  logic                   clk_i,
  input  dfc_adv_t               adv_i,
  input  logic [SEG_W-1:0]       seg_i,
  input  logic [FRACTION_BITS:0] off_i,
  output logic [CHAN_W-1:0]      value_o
);

  localparam int unsigned TW = FRACTION_BITS + 1;
  localparam int unsigned XW = FRACTION_BITS + 9;
  localparam int unsigned K  = FRACTION_BITS + 9;
  localparam int unsigned PW = XW + 1;
  localparam int unsigned QW = 9;

  localparam logic [TW-1:0] POS [NUM_STOPS] = '{
    TW'(stop_pos(STOP_PCT[0], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[1], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[2], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[3], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[4], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[5], FRACTION_BITS)),
    TW'(stop_pos(STOP_PCT[6], FRACTION_BITS))
  };

  localparam logic [TW-1:0] SPAN [NUM_SEG] = '{
    POS[1] - POS[0], POS[2] - POS[1], POS[3] - POS[2],
    POS[4] - POS[3], POS[5] - POS[4], POS[6] - POS[5]
  };

  localparam logic [RECIP_W-1:0] RECIP [NUM_SEG] = '{
    RECIP_W'((64'd1 << K) / 64'(SPAN[0])),
    RECIP_W'((64'd1 << K) / 64'(SPAN[1])),
    RECIP_W'((64'd1 << K) / 64'(SPAN[2])),
    RECIP_W'((64'd1 << K) / 64'(SPAN[3])),
    RECIP_W'((64'd1 << K) / 64'(SPAN[4])),
    RECIP_W'((64'd1 << K) / 64'(SPAN[5]))
  };

  // Stage 4: scaled offset, biased for a ceiling when the channel falls
  logic [CHAN_W-1:0] a_s4, b_s4, delta_s4;
  logic              down_s4;
  logic [XW-1:0]     x_d, x_q;
  logic [SEG_W-1:0]  seg4_q;

  always_comb begin
    a_s4     = STOP_RGB[seg_i][CH];
    b_s4     = STOP_RGB[seg_i + SEG_W'(1)][CH];
    down_s4  = (b_s4 < a_s4);
    delta_s4 = down_s4 ? (a_s4 - b_s4) : (b_s4 - a_s4);
    x_d      = XW'(off_i) * XW'(delta_s4);
    if (down_s4) begin
      x_d = x_d + XW'(SPAN[seg_i]) - XW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      x_q    <= x_d;
      seg4_q <= seg_i;
    end
  end

  // Stage 5: quotient estimate, low by at most one
  logic [XW+RECIP_W-1:0] rp_s5;
  logic [QW-1:0]         qe_d, qe5_q;
  logic [XW-1:0]         x5_q;
  logic [SEG_W-1:0]      seg5_q;

  always_comb begin
    rp_s5 = (XW+RECIP_W)'(x_q) * (XW+RECIP_W)'(RECIP[seg4_q]);
    qe_d  = rp_s5[K+QW-1:K];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      qe5_q  <= qe_d;
      x5_q   <= x_q;
      seg5_q <= seg4_q;
    end
  end

  // Stage 6: back-multiply the estimate
  logic [PW-1:0]    p2_d, p2_q;
  logic [QW-1:0]    qe6_q;
  logic [XW-1:0]    x6_q;
  logic [SEG_W-1:0] seg6_q;

  assign p2_d = PW'(qe5_q) * PW'(SPAN[seg5_q]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s6) begin
      p2_q   <= p2_d;
      qe6_q  <= qe5_q;
      x6_q   <= x5_q;
      seg6_q <= seg5_q;
    end
  end

  // Stage 7: correct the quotient, apply it to the lower stop and clamp
  logic [PW-1:0]       rem_s7;
  logic [QW-1:0]       q_s7;
  logic [CHAN_W-1:0]   a_s7, b_s7;
  logic signed [QW:0]  v_s7;
  logic [CHAN_W-1:0]   value_d, value_q;

  always_comb begin
    a_s7   = STOP_RGB[seg6_q][CH];
    b_s7   = STOP_RGB[seg6_q + SEG_W'(1)][CH];
    rem_s7 = PW'(x6_q) - p2_q;
    q_s7   = qe6_q + QW'(rem_s7 >= PW'(SPAN[seg6_q]));
    if (b_s7 < a_s7) begin
      v_s7 = signed'((QW+1)'(a_s7)) - signed'((QW+1)'(q_s7));
    end else begin
      v_s7 = signed'((QW+1)'(a_s7)) + signed'((QW+1)'(q_s7));
    end
    if (v_s7 < 0) begin
      value_d = '0;
    end else if (v_s7 > signed'((QW+1)'(255))) begin
      value_d = '1;
    end else begin
      value_d = v_s7[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s7) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

// ===== tb/sv/db_to_false_color_pixel_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// db_to_false_color_pixel_core_tb
// Self-checking bench for the dB to false-colour pixel core. A queue-fed
// driver offers sample transactions in random bursts, a monitor takes pixel
// transactions under a random stall pattern, and a local colormap model
// predicts each pixel from the register settings in force.
// ----------------------------------------------------------------------------
module db_to_false_color_pixel_core_tb;
  import dfc_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned SMP_BITS    = 16;
  localparam longint      T_ONE       = longint'(1) << FRAC_BITS;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          RAND_PHASES = 7;
  localparam int          PHASE_ITEMS = 185;
  localparam int          HOLD_CYCLES = 80;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  dfc_sample_if #(.SAMPLE_BITS(SMP_BITS)) smp_if ();
  dfc_pixel_if                            pix_if ();

  db_to_false_color_pixel_core #(
    .FRACTION_BITS(FRAC_BITS),
    .SAMPLE_BITS  (SMP_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .sample_i  (smp_if.sink),
    .pixel_o   (pix_if.source)
  );

  // Local copy of the two registers, updated as each write lands.
  logic signed [FLOOR_W-1:0] floor_q88 = DB_FLOOR_RESET;
  logic [SPAN_W-1:0]         inv_span  = INV_SPAN_RESET;

  logic signed [SMP_BITS-1:0] sample_backlog [$];
  rgb_t                       expected_pixels [$];

  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_settings = 1;
  int cycles     = 0;

  // Idling knobs, changed only between phases.
  int max_gap   = 0;
  int stall_pct = 0;

  // Sender burst state.
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver stall state and the one long hold-off.
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Colormap model
  // --------------------------------------------------------------------------

  // Stop position in fixed point, rounded to nearest.
  function automatic longint knot_pos(input int k);
    longint pct;
    case (k)
      0:       pct = 0;
      1:       pct = 15;
      2:       pct = 35;
      3:       pct = 55;
      4:       pct = 75;
      5:       pct = 90;
      default: pct = 100;
    endcase
    return ((pct << FRAC_BITS) + 50) / 100;
  endfunction

  function automatic logic [23:0] knot_rgb(input int k);
    case (k)
      0:       return {8'd8,   8'd0,   8'd64 };
      1:       return {8'd0,   8'd0,   8'd180};
      2:       return {8'd0,   8'd160, 8'd200};
      3:       return {8'd0,   8'd210, 8'd80 };
      4:       return {8'd230, 8'd230, 8'd0  };
      5:       return {8'd255, 8'd120, 8'd0  };
      default: return {8'd255, 8'd255, 8'd255};
    endcase
  endfunction

  function automatic rgb_t map_to_pixel(input logic signed [SMP_BITS-1:0] s);
    longint      d;
    longint      t;
    longint      p_lo;
    longint      width;
    longint      off;
    longint      a;
    longint      b;
    longint      v;
    int          seg;
    logic [23:0] c_lo;
    logic [23:0] c_hi;
    logic [7:0]  chan [3];
    rgb_t        px;
    d = longint'(s) - longint'(floor_q88);
    if (d <= 0 || inv_span == '0) begin
      t = 0;
    end else begin
      t = (d * longint'(inv_span)) >>> (32 - FRAC_BITS);
      if (t > T_ONE) t = T_ONE;
    end
    // Walk down so that the lowest stop at or above t wins; a tie at a stop
    // falls into the segment below it.
    seg = 5;
    for (int k = 6; k >= 1; k--) begin
      if (knot_pos(k) >= t) seg = k - 1;
    end
    p_lo  = knot_pos(seg);
    width = knot_pos(seg + 1) - p_lo;
    off   = t - p_lo;
    c_lo  = knot_rgb(seg);
    c_hi  = knot_rgb(seg + 1);
    for (int c = 0; c < 3; c++) begin
      a = longint'(c_lo[23 - 8*c -: 8]);
      b = longint'(c_hi[23 - 8*c -: 8]);
      v = a * width + off * (b - a);
      if (v < 0) v = 0;
      v = v / width;
      if (v > 255) v = 255;
      chan[c] = v[7:0];
    end
    px.red   = chan[0];
    px.green = chan[1];
    px.blue  = chan[2];
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued samples in bursts, predict each one on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (smp_if.valid && smp_if.ready) begin
      expected_pixels.push_back(map_to_pixel(smp_if.sample_db));
      n_accepted++;
    end
    // Hold the current transaction until it is taken.
    if (!smp_if.valid || smp_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        smp_if.valid <= 1'b0;
      end else if (sample_backlog.size() > 0) begin
        smp_if.valid     <= 1'b1;
        smp_if.sample_db <= sample_backlog.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = $urandom_range(0, max_gap);
        end
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each pixel transaction with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rgb_t want;
    if (pix_if.valid && pix_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d", pix_if.red, pix_if.green, pix_if.blue);
        n_errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (pix_if.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, pix_if.red);
          n_errors++;
        end
        if (pix_if.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, pix_if.green);
          n_errors++;
        end
        if (pix_if.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, pix_if.blue);
          n_errors++;
        end
      end
      n_checked++;
    end
    // Drop ready for one long stretch while a full backlog keeps the sender
    // busy, so the pipeline fills and back-pressures the sample side.
    if (hold_left > 0) begin
      hold_left--;
      pix_if.ready <= 1'b0;
    end else if (!hold_done && sample_backlog.size() >= 100) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      pix_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pix_if.ready <= 1'b0;
    end else if (int'($urandom_range(0, 99)) < stall_pct) begin
      stall_left = $urandom_range(0, 4);
      pix_if.ready <= 1'b0;
    end else begin
      pix_if.ready <= 1'b1;
    end
  end

  // Abort a run that stops making progress.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("db_to_false_color_pixel_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------

  // Advance until every queued sample has come back as a checked pixel.
  task automatic drain();
    while (sample_backlog.size() != 0 || smp_if.valid || n_checked != n_accepted)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write one register while the pipeline is empty and mirror it locally.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DB_FLOOR) floor_q88 = value[FLOOR_W-1:0];
    else                     inv_span  = value[SPAN_W-1:0];
  endtask

  task automatic set_regs(input logic signed [FLOOR_W-1:0] fl, input logic [SPAN_W-1:0] inv);
    drain();
    write_reg(CFG_DB_FLOOR, CFG_W'($unsigned(fl)));
    write_reg(CFG_INV_SPAN, inv);
    n_settings++;
  endtask

  // One random register setting followed by samples aimed mostly at the
  // mapped range, with a share of samples anywhere in the field.
  task automatic random_phase(input int n_items);
    logic signed [FLOOR_W-1:0] fl;
    logic [SPAN_W-1:0]         inv;
    longint                    span_units;
    int                        pick;
    int                        off;
    pick = $urandom_range(0, 9);
    fl   = FLOOR_W'($urandom());
    case (pick)
      0: begin
        inv        = '0;
        span_units = 65535;
      end
      1: begin
        inv        = '1;
        span_units = 2;
      end
      2: begin
        inv        = $urandom();
        span_units = (inv == '0) ? 65535 : ((longint'(1) << 32) / longint'(inv));
      end
      default: begin
        span_units = $urandom_range(2, 40000);
        inv        = SPAN_W'((longint'(1) << 32) / span_units);
      end
    endcase
    if (span_units > 65535) span_units = 65535;
    set_regs(fl, inv);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        off = int'($urandom_range(0, int'(span_units) + 64)) - 32;
        sample_backlog.push_back(SMP_BITS'(int'(fl) + off));
      end else begin
        sample_backlog.push_back(SMP_BITS'($urandom()));
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_DB_FLOOR;
    cfg_data_i       = '0;
    smp_if.valid     = 1'b0;
    smp_if.sample_db = '0;
    pix_if.ready     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: field extremes, alternating bit patterns, the floor
    // itself and the top of the default span.
    sample_backlog.push_back(-16'sd32768);
    sample_backlog.push_back(16'sd32767);
    sample_backlog.push_back(16'sd0);
    sample_backlog.push_back(-16'sd1);
    sample_backlog.push_back(-16'sd25600);
    sample_backlog.push_back(-16'sd25599);
    sample_backlog.push_back(16'h5555);
    sample_backlog.push_back(16'hAAAA);
    drain();

    // Unit scale from the bottom of the range, so that t equals the offset:
    // land just below and exactly on each inner stop.
    set_regs(-16'sd32768, 32'h0001_0000);
    for (int k = 1; k <= 5; k++) begin
      sample_backlog.push_back(SMP_BITS'(-32768 + knot_pos(k) - 1));
      sample_backlog.push_back(SMP_BITS'(-32768 + knot_pos(k)));
    end
    sample_backlog.push_back(16'sd32767);
    drain();

    // Zero reciprocal span: every sample maps to the first stop.
    set_regs(-16'sd32768, 32'h0000_0000);
    sample_backlog.push_back(16'sd32767);
    drain();

    // Largest reciprocal span: floor at the top, then at the bottom so that
    // one step past the floor only just misses saturation and two overflow.
    set_regs(16'sd32767, 32'hFFFF_FFFF);
    sample_backlog.push_back(16'sd32767);
    drain();
    set_regs(-16'sd32768, 32'hFFFF_FFFF);
    sample_backlog.push_back(-16'sd32767);
    sample_backlog.push_back(-16'sd32766);
    drain();

    // Random part: vary the idling per phase, starting with no sender gaps or random stalls.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 3)
        0: begin
          max_gap   = 0;
          stall_pct = 0;
        end
        1: begin
          max_gap   = 3;
          stall_pct = 25;
        end
        default: begin
          max_gap   = 8;
          stall_pct = 60;
        end
      endcase
      random_phase(PHASE_ITEMS);
    end

    drain();
    if (expected_pixels.size() != 0) begin
      $error("%0d pixels never arrived", expected_pixels.size());
      n_errors++;
    end
    $display("Run covered %0d samples over %0d register settings, %0d pixels compared.",
             n_accepted, n_settings, n_checked);
    $display("Long sink hold-off applied: %0d; mismatches: %0d.", hold_done, n_errors);
    if (n_errors == 0) begin
      $display("db_to_false_color_pixel_core verification clean");
    end else begin
      $display("db_to_false_color_pixel_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dfc_pkg.sv
hdl/dfc_sample_if.sv
hdl/dfc_pixel_if.sv
hdl/dfc_chan.sv
hdl/db_to_false_color_pixel_core.sv
tb/sv/db_to_false_color_pixel_core_tb.sv
